FILE: hdl/gdbd_pkg.sv
// ----------------------------------------------------------------------------
// gdbd_pkg
// Shared types and constants for the Gregorian day counter: the command word
// from controller to datapath and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
package gdbd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;

    // day numbers from year 0 exceed 2^22 but stay below 2^23 for 14-bit years
    localparam int DNUM_W  = 23;

    localparam int MUL_A_W = 14;
    localparam int MUL_B_W = 11;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // floor(q / 25) = (q * 1311) >> 15, exact for q below 4096
    localparam logic [MUL_B_W-1:0] RECIP_25   = 11'd1311;
    localparam int                 RECIP_SHIFT = 15;
    localparam logic [MUL_B_W-1:0] CENTURY    = 11'd100;
    localparam logic [MUL_B_W-1:0] YEAR_DAYS  = 11'd365;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    // accept edge to strobe cycle
    localparam int LATENCY = 14;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIVP,
        OP_DIVY,
        OP_REM,
        OP_YDAYS,
        OP_SUM1,
        OP_SUM2,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel;      // 0: start date, 1: end date
    } t_cmd;

    // days before the first of the month in a common year
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/gregorian_days_between_dates_top.sv
// ----------------------------------------------------------------------------
// gregorian_days_between_dates_top
// Counts the days from a start date to an end date in the Gregorian
// calendar, flagging an out-of-range month or a start after the end.
// ----------------------------------------------------------------------------
// Usage:
//   Present both dates and raise start; the word is taken at a rising edge
//   where start is high and busy is low. busy then stays high while the
//   controller walks the datapath through the day number of each date
//   (divide by 100 twice, remainder, year*365, leap sum, month and day)
//   and the final subtract-and-clamp.
//   Result: o_strobe is high for one cycle, registered from the final
//   step, with o_day_count and o_date_error valid in that cycle.
//   A new word is taken only once busy is low again, after the 13
//   controller steps around the single shared multiplier and the idle state.
//   On a bad date o_date_error is 1 and o_day_count is 0. Counts above
//   the 22-bit range saturate; negative walks from impossible days give 0.
//   The receiver cannot stall: the result holds only until the next word
//   finishes. Reset (synchronous, active low) returns the controller to idle
//   and drops any word in progress without a strobe.
// ----------------------------------------------------------------------------
module gregorian_days_between_dates_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [gdbd_pkg::DAY_W-1:0]     i_start_day,
    input  logic [gdbd_pkg::MONTH_W-1:0]   i_start_month,
    input  logic [gdbd_pkg::YEAR_W-1:0]    i_start_year,
    input  logic [gdbd_pkg::DAY_W-1:0]     i_end_day,
    input  logic [gdbd_pkg::MONTH_W-1:0]   i_end_month,
    input  logic [gdbd_pkg::YEAR_W-1:0]    i_end_year,
    output logic                           o_strobe,
    output logic [gdbd_pkg::COUNT_W-1:0]   o_day_count,
    output logic                           o_date_error
);
    import gdbd_pkg::*;

    t_cmd cmd;

    // sequencer
    gdbd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    // arithmetic
    gdbd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_start_day   (i_start_day),
        .i_start_month (i_start_month),
        .i_start_year  (i_start_year),
        .i_end_day     (i_end_day),
        .i_end_month   (i_end_month),
        .i_end_year    (i_end_year),
        .o_day_count   (o_day_count),
        .o_date_error  (o_date_error)
    );

    // result comes back a fixed time after acceptance
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("result strobe missing after accepted word");

    // strobe only once the sequence has finished
    a_strobe_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("strobe while controller still busy");

    // error results carry a zero count
    a_error_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_date_error) |-> (o_day_count == '0))
        else $error("error result with non-zero count");

    // acceptance starts the sequence
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequence");

endmodule

FILE: hdl/gdbd_ctrl.sv
// ----------------------------------------------------------------------------
// gdbd_ctrl
// Sequencer for the day counter: steps the datapath through the day number
// of the start date, then of the end date, then the final difference.
// ----------------------------------------------------------------------------
module gdbd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_strobe,
    output gdbd_pkg::t_cmd o_cmd
);
    import gdbd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVP,
        ST_DIVY,
        ST_REM,
        ST_YDAYS,
        ST_SUM1,
        ST_SUM2,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_sel, n_sel;
    logic   r_strobe, n_strobe;

    // next state and command decode
    always_comb begin
        n_state  = r_state;
        n_sel    = r_sel;
        n_strobe = 1'b0;
        o_cmd.op  = OP_NONE;
        o_cmd.sel = r_sel;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    n_sel    = 1'b0;
                    n_state  = ST_DIVP;
                end
            end
            ST_DIVP: begin
                o_cmd.op = OP_DIVP;
                n_state  = ST_DIVY;
            end
            ST_DIVY: begin
                o_cmd.op = OP_DIVY;
                n_state  = ST_REM;
            end
            ST_REM: begin
                o_cmd.op = OP_REM;
                n_state  = ST_YDAYS;
            end
            ST_YDAYS: begin
                o_cmd.op = OP_YDAYS;
                n_state  = ST_SUM1;
            end
            ST_SUM1: begin
                o_cmd.op = OP_SUM1;
                n_state  = ST_SUM2;
            end
            ST_SUM2: begin
                o_cmd.op = OP_SUM2;
                if (r_sel) begin
                    n_state = ST_FINISH;
                end else begin
                    n_sel   = 1'b1;
                    n_state = ST_DIVP;
                end
            end
            ST_FINISH: begin
                o_cmd.op = OP_FINISH;
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold state and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sel    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sel    <= n_sel;
            r_strobe <= n_strobe;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;

endmodule

FILE: hdl/gdbd_datapath.sv
// ----------------------------------------------------------------------------
// gdbd_datapath
// Day-number datapath: one shared multiplier forms year*365, the divisions
// by 100 and the century product for year % 100, adders build the day number
// of each date, and the final step subtracts, clamps and flags bad dates.
// ----------------------------------------------------------------------------
module gdbd_datapath (
    input  logic                           i_clk,
    input  gdbd_pkg::t_cmd                 i_cmd,
    input  logic [gdbd_pkg::DAY_W-1:0]     i_start_day,
    input  logic [gdbd_pkg::MONTH_W-1:0]   i_start_month,
    input  logic [gdbd_pkg::YEAR_W-1:0]    i_start_year,
    input  logic [gdbd_pkg::DAY_W-1:0]     i_end_day,
    input  logic [gdbd_pkg::MONTH_W-1:0]   i_end_month,
    input  logic [gdbd_pkg::YEAR_W-1:0]    i_end_year,
    output logic [gdbd_pkg::COUNT_W-1:0]   o_day_count,
    output logic                           o_date_error
);
    import gdbd_pkg::*;

    // captured word
    logic [DAY_W-1:0]   r_sd, r_ed;
    logic [MONTH_W-1:0] r_sm, r_em;
    logic [YEAR_W-1:0]  r_sy, r_ey;

    // working registers
    logic [7:0]        r_cp;     // (year-1) / 100
    logic [7:0]        r_cy;     // year / 100
    logic [6:0]        r_ry;     // year % 100
    logic [DNUM_W-1:0] r_acc;
    logic [DNUM_W-1:0] r_dn_start, r_dn_end;
    logic [COUNT_W-1:0] r_count;
    logic               r_error;

    logic [YEAR_W-1:0]  y_sel, p_sel;
    logic [MONTH_W-1:0] m_sel;
    logic [DAY_W-1:0]   d_sel;
    logic [YEAR_W-3:0]  q4p, q4y;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [12:0]        leaps;
    logic               leap_add;
    logic [DNUM_W-1:0]  dnum;
    logic [DNUM_W:0]    diff;
    logic               bad;

    // select the date in work
    assign y_sel = i_cmd.sel ? r_ey : r_sy;
    assign m_sel = i_cmd.sel ? r_em : r_sm;
    assign d_sel = i_cmd.sel ? r_ed : r_sd;
    assign p_sel = y_sel - YEAR_W'(1);
    assign q4p   = p_sel[YEAR_W-1:2];
    assign q4y   = y_sel[YEAR_W-1:2];

    // steer the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_DIVP: begin
                mul_a = MUL_A_W'(q4p);
                mul_b = RECIP_25;
            end
            OP_DIVY: begin
                mul_a = MUL_A_W'(q4y);
                mul_b = RECIP_25;
            end
            OP_REM: begin
                mul_a = MUL_A_W'(r_cy);
                mul_b = CENTURY;
            end
            OP_YDAYS: begin
                mul_a = y_sel;
                mul_b = YEAR_DAYS;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // leap years before the year: p/4 - p/100 + p/400 + 1, none before year 0
    assign leaps = (y_sel == '0) ? 13'd0
                 : 13'(q4p) + 13'(r_cp[7:2]) + 13'd1 - 13'(r_cp);

    // extra day after February in a leap year
    assign leap_add = (m_sel > MONTH_W'(2)) && (y_sel[1:0] == 2'b00)
                    && ((r_ry != '0) || (r_cy[1:0] == 2'b00));

    assign dnum = r_acc + DNUM_W'(month_start(m_sel)) + DNUM_W'(leap_add)
                + DNUM_W'(d_sel);

    assign diff = {1'b0, r_dn_end} - {1'b0, r_dn_start};

    // month out of range, or start later than end
    always_comb begin
        bad = 1'b0;
        if (!(r_sm inside {[4'd1:4'd12]}) || !(r_em inside {[4'd1:4'd12]})) begin
            bad = 1'b1;
        end else if (r_sy > r_ey) begin
            bad = 1'b1;
        end else if ((r_sy == r_ey) && (r_sm > r_em)) begin
            bad = 1'b1;
        end else if ((r_sy == r_ey) && (r_sm == r_em) && (r_sd > r_ed)) begin
            bad = 1'b1;
        end
    end

    // advance the datapath on each command
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_sd <= i_start_day;
                r_sm <= i_start_month;
                r_sy <= i_start_year;
                r_ed <= i_end_day;
                r_em <= i_end_month;
                r_ey <= i_end_year;
            end
            OP_DIVP: begin
                r_cp <= prod[RECIP_SHIFT+7:RECIP_SHIFT];
            end
            OP_DIVY: begin
                r_cy <= prod[RECIP_SHIFT+7:RECIP_SHIFT];
            end
            OP_REM: begin
                r_ry <= 7'(y_sel - prod[YEAR_W-1:0]);
            end
            OP_YDAYS: begin
                r_acc <= prod[DNUM_W-1:0];
            end
            OP_SUM1: begin
                r_acc <= r_acc + DNUM_W'(leaps);
            end
            OP_SUM2: begin
                if (i_cmd.sel) begin
                    r_dn_end <= dnum;
                end else begin
                    r_dn_start <= dnum;
                end
            end
            OP_FINISH: begin
                r_error <= bad;
                if (bad || diff[DNUM_W]) begin
                    r_count <= '0;
                end else if (diff[DNUM_W-1]) begin
                    r_count <= COUNT_MAX;
                end else begin
                    r_count <= diff[COUNT_W-1:0];
                end
            end
            default: begin
                r_count <= r_count;
            end
        endcase
    end

    assign o_day_count  = r_count;
    assign o_date_error = r_error;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Gregorian day counter. A scoreboard predicts
// the day span and error flag of every accepted date pair and compares each
// strobed result with the oldest prediction. Directed pairs cover bad
// months, reversed dates, leap rules, year zero, large years, saturation and
// impossible days; random pairs follow, mostly well-ordered dates.
// ----------------------------------------------------------------------------
module tb;

    import gdbd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 100;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               date_error;
    } t_span_result;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each word and checks results in order
    // ------------------------------------------------------------------------
    class day_span_board;
        t_span_result expected_spans[$];
        int unsigned  days_before_month[12] =
            '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        int           n_words;
        int           n_bad_dates;
        int           n_saturated;
        int           n_clamped;
        int           n_mismatches;
        int           n_unexpected;

        function new();
            n_words      = 0;
            n_bad_dates  = 0;
            n_saturated  = 0;
            n_clamped    = 0;
            n_mismatches = 0;
            n_unexpected = 0;
        endfunction

        function bit leap_year(int unsigned y);
            return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        endfunction

        // leap years in [0, y), year zero included
        function longint leap_years_below(int unsigned y);
            if (y == 0)
                return 0;
            return (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
        endfunction

        // days since the start of year zero; month must be 1..12
        function longint day_index(int unsigned d, int unsigned m, int unsigned y);
            longint n;
            n = longint'(y) * 365 + leap_years_below(y) + days_before_month[m - 1];
            if (m > 2 && leap_year(y))
                n++;
            return n + d;
        endfunction

        function void note_word(logic [DAY_W-1:0] sd, logic [MONTH_W-1:0] sm,
                                logic [YEAR_W-1:0] sy, logic [DAY_W-1:0] ed,
                                logic [MONTH_W-1:0] em, logic [YEAR_W-1:0] ey);
            t_span_result r;
            longint       span;
            bit           bad;
            bad = (sm < 1) || (sm > 12) || (em < 1) || (em > 12) ||
                  ({sy, sm, sd} > {ey, em, ed});
            n_words++;
            if (bad) begin
                r.day_count  = '0;
                r.date_error = 1'b1;
                n_bad_dates++;
            end else begin
                span = day_index(ed, em, ey) - day_index(sd, sm, sy);
                // clamp negative walks, saturate long spans
                if (span < 0) begin
                    span = 0;
                    n_clamped++;
                end
                if (span > longint'(COUNT_MAX)) begin
                    span = longint'(COUNT_MAX);
                    n_saturated++;
                end
                r.day_count  = span[COUNT_W-1:0];
                r.date_error = 1'b0;
            end
            expected_spans.push_back(r);
        endfunction

        function void check_result(logic [COUNT_W-1:0] day_count, logic date_error);
            t_span_result want;
            if (expected_spans.size() == 0) begin
                n_unexpected++;
                if (n_unexpected + n_mismatches <= REPORT_MAX)
                    $display("%0t: result with nothing pending: count=%0d error=%0b",
                             $realtime, day_count, date_error);
                return;
            end
            want = expected_spans.pop_front();
            if (day_count !== want.day_count || date_error !== want.date_error) begin
                n_mismatches++;
                if (n_unexpected + n_mismatches <= REPORT_MAX)
                    $display("%0t: mismatch: count exp %0d got %0d, error exp %0b got %0b",
                             $realtime, want.day_count, day_count,
                             want.date_error, date_error);
            end
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction

        function int failures();
            return n_mismatches + n_unexpected + expected_spans.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block and stimulus signals
    // ------------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [DAY_W-1:0]    i_start_day;
    logic [MONTH_W-1:0]  i_start_month;
    logic [YEAR_W-1:0]   i_start_year;
    logic [DAY_W-1:0]    i_end_day;
    logic [MONTH_W-1:0]  i_end_month;
    logic [YEAR_W-1:0]   i_end_year;
    logic                o_strobe;
    logic [COUNT_W-1:0]  o_day_count;
    logic                o_date_error;

    day_span_board sb;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    gregorian_days_between_dates_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_start_day   (i_start_day),
        .i_start_month (i_start_month),
        .i_start_year  (i_start_year),
        .i_end_day     (i_end_day),
        .i_end_month   (i_end_month),
        .i_end_year    (i_end_year),
        .o_strobe      (o_strobe),
        .o_day_count   (o_day_count),
        .o_date_error  (o_date_error)
    );

    // Check every strobed result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1)
            sb.check_result(o_day_count, o_date_error);
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Present one date pair and hold it until the block takes the word
    // ------------------------------------------------------------------------
    task automatic drive_word(input logic [DAY_W-1:0] sd, input logic [MONTH_W-1:0] sm,
                              input logic [YEAR_W-1:0] sy, input logic [DAY_W-1:0] ed,
                              input logic [MONTH_W-1:0] em, input logic [YEAR_W-1:0] ey);
        int unsigned gap;
        bit          lowered;
        gap     = $urandom_range(0, 3);
        lowered = 1'b0;
        // half the time let the block go idle first, so gaps land there too
        if ($urandom_range(0, 1) == 1) begin
            start   <= 1'b0;
            lowered  = 1'b1;
            do @(posedge i_clk); while (busy);
        end
        if (gap > 0) begin
            if (!lowered)
                start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_start_day   <= sd;
        i_start_month <= sm;
        i_start_year  <= sy;
        i_end_day     <= ed;
        i_end_month   <= em;
        i_end_year    <= ey;
        do @(posedge i_clk); while (busy);
        sb.note_word(sd, sm, sy, ed, em, ey);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed pairs, random pairs, drain, verdict
    // ------------------------------------------------------------------------
    initial begin : main_seq
        logic [DAY_W-1:0]   sd, ed, td;
        logic [MONTH_W-1:0] sm, em, tm;
        logic [YEAR_W-1:0]  sy, ey, ty;
        int unsigned        reach;
        int unsigned        kind;

        sb             = new();
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_start_day   <= '0;
        i_start_month <= '0;
        i_start_year  <= '0;
        i_end_day     <= '0;
        i_end_month   <= '0;
        i_end_year    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: same date, leap rules, year zero, large years
        drive_word(5'd15, 4'd6,  14'd2000,  5'd15, 4'd6,  14'd2000);
        drive_word(5'd1,  4'd1,  14'd0,     5'd1,  4'd3,  14'd0);
        drive_word(5'd28, 4'd2,  14'd1900,  5'd1,  4'd3,  14'd1900);
        drive_word(5'd28, 4'd2,  14'd2000,  5'd1,  4'd3,  14'd2000);
        drive_word(5'd28, 4'd2,  14'd2004,  5'd1,  4'd3,  14'd2004);
        drive_word(5'd1,  4'd12, 14'd1999,  5'd1,  4'd1,  14'd2000);
        drive_word(5'd31, 4'd12, 14'd9999,  5'd1,  4'd1,  14'd10000);
        drive_word(5'd1,  4'd1,  14'd1,     5'd1,  4'd1,  14'd9999);
        drive_word(5'd31, 4'd12, 14'd16383, 5'd31, 4'd12, 14'd16383);
        // Directed: span too long for the count
        drive_word(5'd1,  4'd1,  14'd0,     5'd31, 4'd12, 14'd16383);
        // Directed: bad months
        drive_word(5'd0,  4'd0,  14'd0,     5'd0,  4'd0,  14'd0);
        drive_word(5'd1,  4'd0,  14'd2000,  5'd1,  4'd5,  14'd2000);
        drive_word(5'd1,  4'd3,  14'd2000,  5'd1,  4'd15, 14'd2001);
        drive_word(5'd1,  4'd13, 14'd2000,  5'd1,  4'd12, 14'd2001);
        drive_word(5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383);
        // Directed: start after end, by year, month and day
        drive_word(5'd1,  4'd1,  14'd2001,  5'd1,  4'd1,  14'd2000);
        drive_word(5'd1,  4'd7,  14'd2000,  5'd1,  4'd6,  14'd2000);
        drive_word(5'd2,  4'd1,  14'd0,     5'd1,  4'd1,  14'd0);
        // Directed: impossible days, one negative walk and one plain
        drive_word(5'd31, 4'd2,  14'd2000,  5'd0,  4'd3,  14'd2000);
        drive_word(5'd0,  4'd1,  14'd5,     5'd31, 4'd1,  14'd5);

        // Random: mostly well-ordered pairs, some pure noise
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                sd = DAY_W'($urandom); sm = MONTH_W'($urandom); sy = YEAR_W'($urandom);
                ed = DAY_W'($urandom); em = MONTH_W'($urandom); ey = YEAR_W'($urandom);
            end else begin
                sm = MONTH_W'($urandom_range(1, 12));
                em = MONTH_W'($urandom_range(1, 12));
                sd = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 28));
                ed = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 28));
                sy = YEAR_W'($urandom);
                // most spans short, some centuries, a few across the range
                case ($urandom_range(0, 9))
                    0:       reach = $urandom_range(0, 16383);
                    1, 2, 3: reach = $urandom_range(0, 400);
                    default: reach = $urandom_range(0, 3);
                endcase
                ey = (int'(sy) + reach > 16383) ? 14'd16383 : 14'(int'(sy) + reach);
                // swap so the start is not after the end
                if (kind < 9 && {sy, sm, sd} > {ey, em, ed}) begin
                    td = sd; tm = sm; ty = sy;
                    sd = ed; sm = em; sy = ey;
                    ed = td; em = tm; ey = ty;
                end
            end
            drive_word(sd, sm, sy, ed, em, ey);
        end
        start <= 1'b0;

        // Drain outstanding results, then allow for stray strobes
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Checked %0d date pairs: %0d flagged bad, %0d saturated, %0d clamped to zero.",
                 sb.n_words, sb.n_bad_dates, sb.n_saturated, sb.n_clamped);
        $display("Mismatches %0d, unexpected results %0d, results missing %0d.",
                 sb.n_mismatches, sb.n_unexpected, sb.pending());
        if (sb.failures() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: gregorian_days_between_dates_top.f
hdl/gdbd_pkg.sv
hdl/gdbd_ctrl.sv
hdl/gdbd_datapath.sv
hdl/gregorian_days_between_dates_top.sv
tb/tb.sv
